[rtl/bubble_sort_numeric_keys_defines.svh]
// assertion macros shared by the sorter rtl
`ifndef BUBBLE_SORT_NUMERIC_KEYS_DEFINES_SVH
`define BUBBLE_SORT_NUMERIC_KEYS_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define BSNK_ASSERT_IMPLIES(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BSNK_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/bsnk_pkg.sv]
// shared types and constants of the numeric key sorter
`default_nettype none

package bsnk_pkg;

	localparam int KEY_W = 44;
	localparam int POS_W = 6;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RD0,
		ST_CARRY,
		ST_STEP,
		ST_FLUSH,
		ST_EMIT_RD,
		ST_EMIT_WAIT
	} state_t;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic load;
		logic rd_en;
		logic carry_load;
		logic step;
		logic flush;
		logic emit_load;
		logic emit_last;
		logic clear_set;
	} cmd_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic full;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

[rtl/bsnk_dp.sv]
// datapath: key store, bubble carry register, set counters and result register
`default_nettype none

`include "bubble_sort_numeric_keys_defines.svh"

module bsnk_dp #(
	parameter int CAPACITY = 64,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [bsnk_pkg::KEY_W-1:0] key_value,
	input  wire bsnk_pkg::cmd_t             cmd,
	input  wire logic [AW-1:0]              rd_addr,
	input  wire logic [AW-1:0]              wr_addr,
	output bsnk_pkg::stat_t                 stat,
	output logic [CW-1:0]                   cnt,
	input  wire logic                       result_stall,
	output logic                            result_valid,
	output logic [bsnk_pkg::KEY_W-1:0]      sorted_key,
	output logic [bsnk_pkg::POS_W-1:0]      source_position,
	output logic                            dropped_some,
	output logic                            end_of_run
);
	import bsnk_pkg::*;

	localparam int EW = KEY_W + POS_W;

	// entry layout: {key, arrival position}
	logic [EW-1:0]    mem [CAPACITY];
	logic [EW-1:0]    rdata_q;
	logic [EW-1:0]    carry_q;
	logic [CW-1:0]    cnt_q;
	logic             ovf_q;
	logic             full;
	logic             carry_gt;
	logic             wr_en;
	logic [AW-1:0]    waddr;
	logic [EW-1:0]    wdata;
	logic             out_valid_q;
	logic [KEY_W-1:0] key_q;
	logic [POS_W-1:0] pos_q;
	logic             drop_q;
	logic             eor_q;

	assign full     = (cnt_q == CW'(CAPACITY));
	assign carry_gt = carry_q[EW-1:POS_W] > rdata_q[EW-1:POS_W];

	always_comb begin
		wr_en = (cmd.load && !full) || cmd.step || cmd.flush;
		waddr = wr_addr;
		wdata = carry_q;
		if (cmd.load) begin
			waddr = cnt_q[AW-1:0];
			wdata = {key_value, POS_W'(cnt_q[AW-1:0])};
		end else if (cmd.step) begin
			// smaller of the pair stays behind, larger keeps bubbling
			wdata = carry_gt ? rdata_q : carry_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.carry_load || (cmd.step && !carry_gt)) begin
			carry_q <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.clear_set) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.load) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			key_q  <= rdata_q[EW-1:POS_W];
			pos_q  <= rdata_q[POS_W-1:0];
			drop_q <= ovf_q;
			eor_q  <= cmd.emit_last;
		end
	end

	assign stat.full       = full;
	assign stat.out_free   = !out_valid_q || !result_stall;
	assign cnt             = cnt_q;
	assign result_valid    = out_valid_q;
	assign sorted_key      = key_q;
	assign source_position = pos_q;
	assign dropped_some    = drop_q;
	assign end_of_run      = eor_q;

	`BSNK_ASSERT_IMPLIES(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CW'(CAPACITY), "count past capacity")
	`BSNK_ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, cmd.emit_load, !(out_valid_q && result_stall), "held result overwritten")
	`BSNK_ASSERT_NEXT(a_clear_set, clk, arst_n, cmd.clear_set, cnt_q == '0 && !ovf_q, "set not cleared after run")

endmodule

`default_nettype wire

[rtl/bsnk_ctrl.sv]
// sequencer: load, bubble passes and result emission
`default_nettype none

`include "bubble_sort_numeric_keys_defines.svh"

module bsnk_ctrl #(
	parameter int CAPACITY = 64,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            key_valid,
	input  wire logic            final_key,
	output logic                 key_stall,
	input  wire bsnk_pkg::stat_t stat,
	input  wire logic [CW-1:0]   cnt,
	output bsnk_pkg::cmd_t       cmd,
	output logic [AW-1:0]        rd_addr,
	output logic [AW-1:0]        wr_addr
);
	import bsnk_pkg::*;

	state_t        state_q, state_d;
	logic [AW-1:0] lim_q, lim_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [AW-1:0] idx_inc;
	logic [AW-1:0] idx_dec;
	logic [CW-1:0] cnt_m1;

	assign idx_inc = idx_q + AW'(1);
	assign idx_dec = idx_q - AW'(1);
	assign cnt_m1  = cnt - CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			lim_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			lim_q   <= lim_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		lim_d     = lim_q;
		idx_d     = idx_q;
		cmd       = '0;
		rd_addr   = idx_q;
		wr_addr   = idx_q;
		key_stall = 1'b1;
		unique case (state_q)
			ST_LOAD: begin
				key_stall = 1'b0;
				if (key_valid) begin
					cmd.load = 1'b1;
					if (final_key) begin
						if (!stat.full && cnt == '0) begin
							// single key: nothing to sort
							idx_d   = '0;
							state_d = ST_EMIT_RD;
						end else begin
							lim_d   = stat.full ? cnt_m1[AW-1:0] : cnt[AW-1:0];
							state_d = ST_RD0;
						end
					end
				end
			end
			ST_RD0: begin
				cmd.rd_en = 1'b1;
				rd_addr   = '0;
				idx_d     = '0;
				state_d   = ST_CARRY;
			end
			ST_CARRY: begin
				cmd.carry_load = 1'b1;
				cmd.rd_en      = 1'b1;
				rd_addr        = idx_inc;
				idx_d          = idx_inc;
				state_d        = ST_STEP;
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				wr_addr  = idx_dec;
				if (idx_q == lim_q) begin
					state_d = ST_FLUSH;
				end else begin
					cmd.rd_en = 1'b1;
					rd_addr   = idx_inc;
					idx_d     = idx_inc;
				end
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				wr_addr   = idx_q;
				idx_d     = '0;
				if (lim_q == AW'(1)) begin
					state_d = ST_EMIT_RD;
				end else begin
					// next pass starts its first read here
					cmd.rd_en = 1'b1;
					rd_addr   = '0;
					lim_d     = lim_q - AW'(1);
					state_d   = ST_CARRY;
				end
			end
			ST_EMIT_RD: begin
				cmd.rd_en = 1'b1;
				rd_addr   = idx_q;
				state_d   = ST_EMIT_WAIT;
			end
			ST_EMIT_WAIT: begin
				if (stat.out_free) begin
					cmd.emit_load = 1'b1;
					if (idx_q == cnt_m1[AW-1:0]) begin
						cmd.emit_last = 1'b1;
						cmd.clear_set = 1'b1;
						state_d       = ST_LOAD;
					end else begin
						idx_d   = idx_inc;
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	`BSNK_ASSERT_IMPLIES(a_step_idx, clk, arst_n, state_q == ST_STEP, idx_q <= lim_q && idx_q != '0, "step index out of pass")
	`BSNK_ASSERT_IMPLIES(a_pass_lim, clk, arst_n, state_q == ST_CARRY || state_q == ST_STEP || state_q == ST_FLUSH, lim_q != '0, "empty pass")
	`BSNK_ASSERT_IMPLIES(a_flush_idx, clk, arst_n, state_q == ST_FLUSH, idx_q == lim_q, "flush at wrong slot")

endmodule

`default_nettype wire

[rtl/bubble_sort_numeric_keys.sv]
// top level of the numeric key sorter: sequencer plus datapath
//
//  channel | role   | handshake                   | payload
//  --------+--------+-----------------------------+---------------------------------------------
//  key     | input  | key_valid / key_stall       | key_value, final_key
//  result  | output | result_valid / result_stall | sorted_key, source_position,
//          |        |                             | dropped_some, end_of_run
//
//  loading accepts one key request per cycle; the set closes on final_key
//  sorting then runs n-1 bubble passes over the key store, which has separate read and
//  write ports; a start-up read of slot 0 comes first, then each pass with limit L
//  (L = n-1 down to 1) loads the carry, steps slots 1 to L and flushes the carry to slot L
//  each result then leaves by a store read followed by a result register load
//  arst_n clears the sequencer, set count, overflow flag and result valid only
//  key_stall is high from the final key until the last result is loaded; a
//  result_stall only holds the result register and the emission sequence
`default_nettype none

module bubble_sort_numeric_keys #(
	parameter int CAPACITY = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       key_valid,
	output logic                            key_stall,
	input  wire logic [bsnk_pkg::KEY_W-1:0] key_value,
	input  wire logic                       final_key,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output logic [bsnk_pkg::KEY_W-1:0]      sorted_key,
	output logic [bsnk_pkg::POS_W-1:0]      source_position,
	output logic                            dropped_some,
	output logic                            end_of_run
);
	import bsnk_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	// command and status between sequencer and datapath
	cmd_t          cmd;
	stat_t         stat;
	logic [CW-1:0] cnt;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	// sequencer: tracks pass limit and slot index, issues store reads/writes
	bsnk_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.final_key (final_key),
		.key_stall (key_stall),
		.stat      (stat),
		.cnt       (cnt),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr)
	);

	// datapath: store, carry compare-swap, counters and result register
	bsnk_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.key_value       (key_value),
		.cmd             (cmd),
		.rd_addr         (rd_addr),
		.wr_addr         (wr_addr),
		.stat            (stat),
		.cnt             (cnt),
		.result_stall    (result_stall),
		.result_valid    (result_valid),
		.sorted_key      (sorted_key),
		.source_position (source_position),
		.dropped_some    (dropped_some),
		.end_of_run      (end_of_run)
	);

endmodule

`default_nettype wire
